// ===== rtl/ffls_pkg.sv =====
// shared types and constants for the frame free-list stack
`timescale 1ns / 1ps

package ffls_pkg;

	localparam int ADDR_W      = 64;
	localparam int FADDR_W     = 26;
	localparam int AVAIL_W     = 11;
	localparam int FCOUNT_W    = 11;
	localparam int SHIFT_W     = 5;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 11;

	localparam logic [1:0] OP_REFILL = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SHIFT = 4'd1;

	localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 11'd1024;
	localparam logic [SHIFT_W-1:0]  CHUNK_SHIFT_RST = 5'd12;

	typedef struct packed {
		logic               en;
		logic               left;
		logic [SHIFT_W-1:0] amount;
	} shift_req_t;

endpackage

// ===== rtl/ffls_shift_unit.sv =====
// shared barrel shifter with registered result, left for alloc and right for free
`timescale 1ns / 1ps

module ffls_shift_unit (
	input  logic                       clk,
	input  ffls_pkg::shift_req_t       req,
	input  logic [ffls_pkg::ADDR_W-1:0] operand,
	output logic [ffls_pkg::ADDR_W-1:0] result_q
);
	import ffls_pkg::*;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.left) begin
				result_q <= operand << req.amount;
			end else begin
				result_q <= operand >> req.amount;
			end
		end
	end

endmodule

// ===== rtl/frame_free_list_stack.sv =====
// frame free-list stack allocator: top level with sequencer and index memory
//
// One input channel (operation, free_addr) takes refill, alloc and free commands; one
// output channel returns ok, frame_addr and available for every command. A config channel
// writes frame_count (index 0) and chunk_shift (index 1); the user must do so only while
// the block idles (not enforced). One command at a time; in_ready drops until done:
//   alloc: memory read, shift, result load
//   free:  address shift, range check and push, result load
//   refill: one stack entry written per cycle, min(frame_count, MAX_FRAMES) in all
//   a command that fails its first check, or an unknown one: result load only
// The stack memory has one write and one registered read port, which sets these steps.
// The result sits in an output register; a new command is taken while it waits, and a
// finished command holds in its last step until the receiver takes the previous result.
// Reset empties the pool (available 0) and restores frame_count 1024, chunk_shift 12;
// the stack memory is not cleared, since no entry is read before it is written.
`timescale 1ns / 1ps

module frame_free_list_stack #(
	parameter int MAX_FRAMES      = 1024,
	parameter int MAX_CHUNK_SHIFT = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [ffls_pkg::ADDR_W-1:0]    free_addr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           ok,
	output logic [ffls_pkg::FADDR_W-1:0]   frame_addr,
	output logic [ffls_pkg::AVAIL_W-1:0]   available,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ffls_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REFILL,
		ST_ARD,
		ST_ASHIFT,
		ST_FSHIFT,
		ST_FCHK,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [FCOUNT_W-1:0]  frame_count_q;
	logic [SHIFT_W-1:0]   chunk_shift_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     val_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 res_ok_q;
	logic                 res_alloc_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic [FADDR_W-1:0]   frame_addr_q;
	logic [AVAIL_W-1:0]   available_q;

	logic [IDX_W-1:0]     mem [MAX_FRAMES];
	logic [IDX_W-1:0]     rdata_q;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [IDX_W-1:0]     mem_wdata;

	logic [CNT_W-1:0]     cap;
	logic [SHIFT_W-1:0]   sh;
	logic                 in_fire;
	logic                 free_hit;
	logic                 out_free;
	shift_req_t           shift_req;
	logic [ADDR_W-1:0]    shift_operand;
	logic [ADDR_W-1:0]    shift_result;

	// effective frame count and shift after clamping
	always_comb begin
		if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
			cap = CNT_W'(MAX_FRAMES);
		end else begin
			cap = CNT_W'(frame_count_q);
		end
		if (32'(chunk_shift_q) > 32'(MAX_CHUNK_SHIFT)) begin
			sh = SHIFT_W'(MAX_CHUNK_SHIFT);
		end else begin
			sh = chunk_shift_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign free_hit  = (shift_result < ADDR_W'(cap));

	assign shift_req.en     = (state_q == ST_ASHIFT) || (state_q == ST_FSHIFT);
	assign shift_req.left   = (state_q == ST_ASHIFT);
	assign shift_req.amount = sh;
	assign shift_operand    = (state_q == ST_ASHIFT) ? ADDR_W'(rdata_q) : addr_q;

	ffls_shift_unit u_shift (
		.clk      (clk),
		.req      (shift_req),
		.operand  (shift_operand),
		.result_q (shift_result)
	);

	// stack memory write port
	always_comb begin
		mem_we    = (state_q == ST_REFILL) || ((state_q == ST_FCHK) && free_hit);
		mem_waddr = (state_q == ST_REFILL) ? ptr_q : IDX_W'(count_q);
		mem_wdata = (state_q == ST_REFILL) ? val_q : shift_result[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[ptr_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			chunk_shift_q <= CHUNK_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FCOUNT_W-1:0];
				REG_CHUNK_SHIFT: chunk_shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			val_q        <= '0;
			addr_q       <= '0;
			res_ok_q     <= 1'b0;
			res_alloc_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			ok_q         <= 1'b0;
			frame_addr_q <= '0;
			available_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_ok_q    <= 1'b0;
						res_alloc_q <= 1'b0;
						case (operation)
							OP_REFILL: begin
								if (cap != '0) begin
									ptr_q   <= '0;
									val_q   <= IDX_W'(cap - 1'b1);
									state_q <= ST_REFILL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_ALLOC: begin
								if (count_q != '0) begin
									ptr_q   <= IDX_W'(count_q - 1'b1);
									state_q <= ST_ARD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_FREE: begin
								if (count_q < cap) begin
									addr_q  <= free_addr;
									state_q <= ST_FSHIFT;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_REFILL: begin
					ptr_q <= ptr_q + 1'b1;
					val_q <= val_q - 1'b1;
					if (ptr_q == IDX_W'(cap - 1'b1)) begin
						count_q  <= cap;
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_ARD: begin
					state_q <= ST_ASHIFT;
				end
				ST_ASHIFT: begin
					count_q     <= count_q - 1'b1;
					res_ok_q    <= 1'b1;
					res_alloc_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_FSHIFT: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					if (free_hit) begin
						count_q  <= count_q + 1'b1;
						res_ok_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						ok_q         <= res_ok_q;
						frame_addr_q <= res_alloc_q ? shift_result[FADDR_W-1:0] : '0;
						available_q  <= AVAIL_W'(count_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign frame_addr = frame_addr_q;
	assign available  = available_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(MAX_FRAMES))
		else $error("free count above pool size");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> frame_addr == '0)
		else $error("failed transaction carries a frame address");

	a_refill_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REFILL |-> 32'(ptr_q) < 32'(cap))
		else $error("refill pointer past frame count");
`endif

endmodule
